FILE: rtl/brb_pkg.sv
// Package for the byte ring buffer with region readout.
// Holds the operation codes, the store geometry and the transaction payload types.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package brb_pkg;

   localparam int DEPTH = 256;
   localparam int IDX_W = 8;
   localparam int CNT_W = 9;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CNT_W-1:0] SIZE_MIN = CNT_W'(2);
   localparam logic [CNT_W-1:0] SIZE_MAX = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      FUNC_PUT     = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_CLEAR   = 2'd2,
      FUNC_STATUS  = 2'd3
   } func_type;

   // Register index of buffer_size, taken from the word address.
   localparam logic REG_BUFFER_SIZE = 1'b0;

   typedef struct packed {
      func_type         func;
      logic [7:0]       data_byte;
      logic [CNT_W-1:0] release_length;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0] region_start;
      logic [CNT_W-1:0] region_length;
      logic [7:0]       head_byte;
      logic [CNT_W-1:0] stored_bytes;
      logic [CNT_W-1:0] blank_count;
      logic             has_blank;
      logic             put_dropped;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: rtl/byte_ring_buffer_with_region_readout.sv
// Top level of the byte ring buffer with contiguous region readout.
// Holds the byte store, the indices, the size register and its APB-style port.
// Depends on brb_pkg for the payload types and operation codes.
// Latency: the result strobe rises in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle; busy stays low, since the single read port of
// the store is addressed with the updated read index and a put to that slot is forwarded.
// Reset: indices clear to zero and buffer_size to 256; the byte store is not cleared.
// Results cannot be stalled by the receiver.
`default_nettype none

module byte_ring_buffer_with_region_readout
   import brb_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  req_payload_type             req_payload,
   output logic                        rsp_valid,
   output rsp_payload_type             rsp_payload,
   input  wire                         csr_psel,
   input  wire                         csr_penable,
   input  wire                         csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]       csr_paddr,
   input  wire  [CSR_DATA_W-1:0]       csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   logic [7:0]       store_mem [DEPTH];

   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic [IDX_W-1:0] read_index_ff, read_index_in;
   logic [CNT_W-1:0] size_ff;
   logic [CNT_W-1:0] size_eff;

   logic             rsp_valid_ff;
   rsp_payload_type  rsp_ff, rsp_in;
   logic [7:0]       rd_data_ff;
   logic [7:0]       fwd_byte_ff;
   logic             fwd_ff, fwd_in;
   logic             nonempty_ff;

   logic             accept;
   logic             cfg_write;
   logic             store_write;
   logic             dropped;
   logic [IDX_W-1:0] put_next;
   logic [IDX_W-1:0] blank_next;
   logic [CNT_W-1:0] tail_len;
   logic [CNT_W-1:0] release_rest;
   logic [CNT_W-1:0] count;

   function automatic logic [IDX_W-1:0] step_index(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] size);
      logic [CNT_W-1:0] nxt;
      nxt = {1'b0, idx} + CNT_W'(1);
      return (nxt >= size) ? '0 : nxt[IDX_W-1:0];
   endfunction

   assign accept    = start && !busy;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign busy       = 1'b0;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BUFFER_SIZE) ?
                       {{(CSR_DATA_W-CNT_W){1'b0}}, size_ff} : '0;

   always_comb begin
      if (size_ff < SIZE_MIN) begin
         size_eff = SIZE_MIN;
      end else if (size_ff > SIZE_MAX) begin
         size_eff = SIZE_MAX;
      end else begin
         size_eff = size_ff;
      end
   end

   // Operation decode and index update.
   always_comb begin
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      dropped        = 1'b0;
      store_write    = 1'b0;
      put_next       = step_index(write_index_ff, size_eff);
      tail_len       = size_eff - {1'b0, read_index_ff};
      release_rest   = req_payload.release_length - tail_len;
      unique case (req_payload.func)
         FUNC_PUT: begin
            if (put_next != read_index_ff) begin
               store_write    = 1'b1;
               write_index_in = put_next;
            end else begin
               dropped = 1'b1;
            end
         end
         FUNC_RELEASE: begin
            if (read_index_ff <= write_index_ff) begin
               if (req_payload.release_length > {1'b0, write_index_ff - read_index_ff}) begin
                  read_index_in = write_index_ff;
               end else begin
                  read_index_in = read_index_ff + req_payload.release_length[IDX_W-1:0];
               end
            end else if (req_payload.release_length >= tail_len) begin
               // The release covers the tail and continues from the first slot.
               if (release_rest >= {1'b0, write_index_ff}) begin
                  read_index_in = write_index_ff;
               end else begin
                  read_index_in = release_rest[IDX_W-1:0];
               end
            end else begin
               read_index_in = read_index_ff + req_payload.release_length[IDX_W-1:0];
            end
         end
         FUNC_CLEAR: begin
            write_index_in = '0;
            read_index_in  = '0;
         end
         FUNC_STATUS: begin
         end
         default: begin
         end
      endcase
   end

   // Report fields, computed from the updated indices.
   always_comb begin
      blank_next = step_index(write_index_in, size_eff);
      if (write_index_in >= read_index_in) begin
         count = {1'b0, write_index_in - read_index_in};
      end else begin
         count = {1'b0, write_index_in} + size_eff - {1'b0, read_index_in};
      end
      rsp_in.region_start = read_index_in;
      if (write_index_in == read_index_in) begin
         rsp_in.region_length = '0;
      end else if (read_index_in < write_index_in) begin
         rsp_in.region_length = {1'b0, write_index_in - read_index_in};
      end else begin
         rsp_in.region_length = size_eff - {1'b0, read_index_in};
      end
      rsp_in.head_byte    = '0;
      rsp_in.stored_bytes = count;
      rsp_in.blank_count  = size_eff - count;
      rsp_in.has_blank    = (blank_next != read_index_in);
      rsp_in.put_dropped  = dropped;
      // A put into an empty buffer writes the very slot the head is read from.
      fwd_in = store_write && (write_index_ff == read_index_in);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (store_write) begin
            store_mem[write_index_ff] <= req_payload.data_byte;
         end
         rd_data_ff <= store_mem[read_index_in];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff      <= rsp_in;
         fwd_ff      <= fwd_in;
         fwd_byte_ff <= req_payload.data_byte;
         nonempty_ff <= (write_index_in != read_index_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         read_index_ff  <= '0;
         size_ff        <= SIZE_MAX;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            write_index_ff <= write_index_in;
            read_index_ff  <= read_index_in;
         end
         if (cfg_write && (csr_paddr[2] == REG_BUFFER_SIZE)) begin
            size_ff        <= csr_pwdata[CNT_W-1:0];
            write_index_ff <= '0;
            read_index_ff  <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_payload = rsp_ff;
      if (!nonempty_ff) begin
         rsp_payload.head_byte = '0;
      end else if (fwd_ff) begin
         rsp_payload.head_byte = fwd_byte_ff;
      end else begin
         rsp_payload.head_byte = rd_data_ff;
      end
   end

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, read_index_ff} < size_eff) && ({1'b0, write_index_ff} < size_eff))
      else $error("ring buffer index outside the used slots");

   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_region_within_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.region_length <= rsp_payload.stored_bytes))
      else $error("readable region longer than stored data");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.put_dropped) |-> !rsp_payload.has_blank)
      else $error("put dropped while a slot was free");

endmodule

`default_nettype wire

FILE: bench/tb_byte_ring_buffer_with_region_readout.sv
// Self-checking testbench for byte_ring_buffer_with_region_readout.
// A directed table and random phases run against a predictor of the ring indices and store.
// Depends on brb_pkg and the block's top level; nothing else.
`timescale 1ns / 1ps

module tb_byte_ring_buffer_with_region_readout;
   import brb_pkg::*;

   typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      req_payload_type req;
      logic [8:0]      size_value;
      logic            pinned;
      rsp_payload_type status;
   } plan_row_type;

   localparam logic [CSR_ADDR_W-1:0] BUFFER_SIZE_ADDR = CSR_ADDR_W'({REG_BUFFER_SIZE, 2'b00});
   localparam int SETTLE_CYCLES = 4;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Side band that travels with each transaction: a typed expectation, if any.
   logic                  pin_valid = 1'b0;
   rsp_payload_type       pin_status = '0;

   // Predictor state.
   logic [7:0]            ring_bytes [DEPTH];
   int                    ring_wr = 0;
   int                    ring_rd = 0;
   logic [8:0]            ring_size_reg = 9'd256;

   rsp_payload_type       pending_status [$];
   plan_row_type          directed_plan [$];
   int                    error_count = 0;

   byte_ring_buffer_with_region_readout uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_size(logic [8:0] value);
      if (value < SIZE_MIN) return int'(SIZE_MIN);
      if (value > SIZE_MAX) return int'(SIZE_MAX);
      return int'(value);
   endfunction

   // Performs one operation on the predicted ring and reports its state afterwards.
   task automatic apply_ring_op(input req_payload_type op, output rsp_payload_type res);
      int   eff;
      int   nxt;
      int   len;
      int   tail;
      int   rest;
      int   count;
      int   rlen;
      logic dropped;
      eff = clamp_size(ring_size_reg);
      len = int'(op.release_length);
      dropped = 1'b0;
      rlen = 0;
      res = '0;
      case (op.func)
         FUNC_PUT: begin
            nxt = (ring_wr + 1 >= eff) ? 0 : ring_wr + 1;
            if (nxt != ring_rd) begin
               ring_bytes[ring_wr] = op.data_byte;
               ring_wr = nxt;
            end else begin
               dropped = 1'b1;
            end
         end
         FUNC_RELEASE: begin
            if (ring_rd <= ring_wr) begin
               ring_rd = (len > ring_wr - ring_rd) ? ring_wr : ring_rd + len;
            end else begin
               // The tail up to the end of the used slots goes first, then the front.
               tail = eff - ring_rd;
               if (len >= tail) begin
                  rest = len - tail;
                  ring_rd = (rest >= ring_wr) ? ring_wr : rest;
               end else begin
                  ring_rd = ring_rd + len;
               end
            end
         end
         FUNC_CLEAR: begin
            ring_wr = 0;
            ring_rd = 0;
         end
         default: ;
      endcase
      count = (ring_wr >= ring_rd) ? ring_wr - ring_rd : ring_wr + eff - ring_rd;
      if (ring_wr != ring_rd) begin
         rlen = (ring_rd < ring_wr) ? ring_wr - ring_rd : eff - ring_rd;
         res.head_byte = ring_bytes[ring_rd];
      end
      nxt = (ring_wr + 1 >= eff) ? 0 : ring_wr + 1;
      res.region_start  = IDX_W'(ring_rd);
      res.region_length = CNT_W'(rlen);
      res.stored_bytes  = CNT_W'(count);
      res.blank_count   = CNT_W'(eff - count);
      res.has_blank     = (nxt != ring_rd);
      res.put_dropped   = dropped;
   endtask

   task automatic check_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         error_count++;
      end
   endtask

   // Checks results, tracks register writes and predicts each accepted transaction.
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type predicted;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_status.size() == 0) begin
               $display("%0t: result with no transaction outstanding, actual %h",
                        $time, rsp_payload);
               error_count++;
            end else begin
               want = pending_status.pop_front();
               check_field("region_start", want.region_start, rsp_payload.region_start);
               check_field("region_length", want.region_length, rsp_payload.region_length);
               check_field("head_byte", want.head_byte, rsp_payload.head_byte);
               check_field("stored_bytes", want.stored_bytes, rsp_payload.stored_bytes);
               check_field("blank_count", want.blank_count, rsp_payload.blank_count);
               check_field("has_blank", want.has_blank, rsp_payload.has_blank);
               check_field("put_dropped", want.put_dropped, rsp_payload.put_dropped);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == BUFFER_SIZE_ADDR) begin
            ring_size_reg = csr_pwdata[8:0];
            ring_wr = 0;
            ring_rd = 0;
         end
         if (start && !busy) begin
            apply_ring_op(req_payload, predicted);
            pending_status.push_back(pin_valid ? pin_status : predicted);
         end
      end
   end

   // Called at a rising edge; returns at the edge where the transaction is accepted.
   task automatic issue_item(req_payload_type op, logic pinned, rsp_payload_type status);
      start <= 1'b1;
      req_payload <= op;
      pin_valid <= pinned;
      pin_status <= status;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   task automatic hold_off(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (pending_status.size() != 0);
      @(posedge clock);
   endtask

   task automatic program_size(logic [8:0] value);
      logic [CSR_DATA_W-1:0] word;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      word = $urandom();
      word[8:0] = value;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= BUFFER_SIZE_ADDR;
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic rsp_payload_type status_of(int rs, int rl, int hb, int dc, int bc,
                                                 logic blank, logic dropped);
      rsp_payload_type s;
      s.region_start  = IDX_W'(rs);
      s.region_length = CNT_W'(rl);
      s.head_byte     = 8'(hb);
      s.stored_bytes  = CNT_W'(dc);
      s.blank_count   = CNT_W'(bc);
      s.has_blank     = blank;
      s.put_dropped   = dropped;
      return s;
   endfunction

   task automatic add_row(func_type f, int d, int l, logic pinned, rsp_payload_type s);
      plan_row_type row;
      row.kind = ROW_ITEM;
      row.req.func = f;
      row.req.data_byte = 8'(d);
      row.req.release_length = CNT_W'(l);
      row.size_value = '0;
      row.pinned = pinned;
      row.status = s;
      directed_plan.push_back(row);
   endtask

   task automatic add_size_row(logic [8:0] value);
      plan_row_type row;
      row.kind = ROW_SIZE;
      row.req = '0;
      row.size_value = value;
      row.pinned = 1'b0;
      row.status = '0;
      directed_plan.push_back(row);
   endtask

   task automatic build_directed_plan();
      // Reset state, extremes of the byte, an excess release and a clear.
      add_row(FUNC_STATUS, 8'h00, 0, 1'b1, status_of(0, 0, 0, 0, 256, 1'b1, 1'b0));
      add_row(FUNC_PUT, 8'h00, 0, 1'b0, '0);
      add_row(FUNC_PUT, 8'hFF, 256, 1'b0, '0);
      add_row(FUNC_RELEASE, 8'h5A, 1, 1'b0, '0);
      add_row(FUNC_RELEASE, 8'hA5, 256, 1'b1, status_of(2, 0, 0, 0, 256, 1'b1, 1'b0));
      add_row(FUNC_PUT, 8'h3C, 7, 1'b0, '0);
      add_row(FUNC_CLEAR, 8'hFF, 256, 1'b1, status_of(0, 0, 0, 0, 256, 1'b1, 1'b0));
      // Smallest buffer: one byte fills it, the next put is dropped.
      add_size_row(9'd2);
      add_row(FUNC_PUT, 8'hA5, 0, 1'b1, status_of(0, 1, 8'hA5, 1, 1, 1'b0, 1'b0));
      add_row(FUNC_PUT, 8'h5A, 0, 1'b1, status_of(0, 1, 8'hA5, 1, 1, 1'b0, 1'b1));
      add_row(FUNC_RELEASE, 8'h00, 1, 1'b1, status_of(1, 0, 0, 0, 2, 1'b1, 1'b0));
      add_row(FUNC_PUT, 8'hC3, 0, 1'b1, status_of(1, 1, 8'hC3, 1, 1, 1'b0, 1'b0));
      // Four slots: full, wrap of the write index, release ending at the tail, excess release.
      add_size_row(9'd4);
      add_row(FUNC_PUT, 8'h11, 0, 1'b0, '0);
      add_row(FUNC_PUT, 8'h22, 0, 1'b0, '0);
      add_row(FUNC_PUT, 8'h33, 0, 1'b0, '0);
      add_row(FUNC_PUT, 8'h44, 0, 1'b1, status_of(0, 3, 8'h11, 3, 1, 1'b0, 1'b1));
      add_row(FUNC_RELEASE, 8'h00, 2, 1'b0, '0);
      add_row(FUNC_PUT, 8'h55, 0, 1'b0, '0);
      add_row(FUNC_PUT, 8'h66, 0, 1'b0, '0);
      add_row(FUNC_RELEASE, 8'h00, 0, 1'b0, '0);
      add_row(FUNC_RELEASE, 8'h00, 2, 1'b0, '0);
      add_row(FUNC_PUT, 8'h77, 0, 1'b0, '0);
      add_row(FUNC_RELEASE, 8'h00, 1, 1'b0, '0);
      add_row(FUNC_PUT, 8'h88, 0, 1'b0, '0);
      add_row(FUNC_PUT, 8'h99, 0, 1'b0, '0);
      add_row(FUNC_RELEASE, 8'h00, 256, 1'b1, status_of(0, 0, 0, 0, 4, 1'b1, 1'b0));
      // Sizes outside the legal range are clamped.
      add_size_row(9'd0);
      add_row(FUNC_STATUS, 8'h00, 0, 1'b1, status_of(0, 0, 0, 0, 2, 1'b1, 1'b0));
      add_size_row(9'd511);
      add_row(FUNC_STATUS, 8'h00, 0, 1'b1, status_of(0, 0, 0, 0, 256, 1'b1, 1'b0));
   endtask

   function automatic req_payload_type random_request(int eff);
      req_payload_type op;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) op.func = FUNC_PUT;
      else if (pick < 85) op.func = FUNC_RELEASE;
      else if (pick < 90) op.func = FUNC_CLEAR;
      else op.func = FUNC_STATUS;
      op.data_byte = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 25) op.release_length = CNT_W'($urandom_range(0, 3));
      else if (pick < 85) op.release_length = CNT_W'($urandom_range(0, eff));
      else if (pick < 92) op.release_length = CNT_W'(256);
      else op.release_length = CNT_W'(eff);
      return op;
   endfunction

   task automatic run_phase(logic [8:0] value, int fill_puts, int count, logic steady);
      req_payload_type op;
      int              eff;
      int              burst_left;
      int              gap;
      eff = clamp_size(value);
      burst_left = 0;
      program_size(value);
      // A run of puts first, so a large buffer gets full and wraps.
      for (int i = 0; i < fill_puts; i++) begin
         op = random_request(eff);
         op.func = FUNC_PUT;
         issue_item(op, 1'b0, '0);
      end
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain_results();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) hold_off(gap);
         end
         burst_left--;
         issue_item(random_request(eff), 1'b0, '0);
      end
   endtask

   initial begin
      int waited;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      build_directed_plan();
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_SIZE) begin
            program_size(directed_plan[i].size_value);
         end else begin
            if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 3));
            issue_item(directed_plan[i].req, directed_plan[i].pinned, directed_plan[i].status);
         end
      end
      run_phase(9'd2, 0, 70, 1'b0);
      run_phase(9'd3, 0, 70, 1'b0);
      run_phase(9'($urandom_range(4, 16)), 0, 70, 1'b0);
      run_phase(9'd256, 260, 80, 1'b0);
      run_phase(9'($urandom_range(5, 40)), 0, 70, 1'b1);
      run_phase(9'd0, 0, 60, 1'b0);
      run_phase(9'd1, 0, 60, 1'b1);
      run_phase(9'($urandom_range(257, 511)), 0, 70, 1'b0);
      run_phase(9'($urandom_range(17, 255)), 40, 70, 1'b0);
      run_phase(9'd16, 0, 70, 1'b0);
      start <= 1'b0;
      waited = 0;
      while (pending_status.size() != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_status.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_status.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: byte_ring_buffer_with_region_readout.f
rtl/brb_pkg.sv
rtl/byte_ring_buffer_with_region_readout.sv
bench/tb_byte_ring_buffer_with_region_readout.sv
